// ----- rtl/mbpe_pkg.sv -----
// Shared types and constants for the monochrome bitmap pixel expander.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mbpe_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FILL_MODE  = 2'd0,
    CFG_PEN_COLOR  = 2'd1,
    CFG_BACK_COLOR = 2'd2
  } cfg_idx_e;

  // Input item kinds.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BYTE  = 1'b1
  } item_kind_e;

  localparam int unsigned CoordW     = 16;
  localparam int unsigned ColorW     = 16;
  localparam int unsigned PixPerByte = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ColorW-1:0] PenColorRst  = 16'h0000;
  localparam logic [ColorW-1:0] BackColorRst = 16'hFFFF;

  // One byte of work handed from the front to the back.
  typedef struct packed {
    logic [CoordW-1:0]     x;
    logic [CoordW-1:0]     y;
    logic [PixPerByte-1:0] bits;
    logic [PixPerByte-1:0] wmask;
  } job_t;

  // Colors the back needs to paint pixels.
  typedef struct packed {
    logic [ColorW-1:0] pen;
    logic [ColorW-1:0] back;
  } colors_t;

endpackage

// ----- rtl/mbpe_front.sv -----
// Front end: configuration registers, start-item handling and cursor tracking.
// Classifies bytes into jobs for the queue. Depends on mbpe_pkg.
module mbpe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [mbpe_pkg::ColorW-1:0]  cfg_data_i,
  // Input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [mbpe_pkg::CoordW-1:0]  origin_x_i,
  input  logic [mbpe_pkg::CoordW-1:0]  origin_y_i,
  input  logic [mbpe_pkg::CoordW-1:0]  pic_width_i,
  input  logic [mbpe_pkg::CoordW-1:0]  pic_height_i,
  input  logic [7:0]                   bitmap_byte_i,
  // Queue push side
  output logic                         push_o,
  output mbpe_pkg::job_t               push_job_o,
  input  logic                         q_full_i,
  // Colors for the back end
  output mbpe_pkg::colors_t            colors_o
);
  import mbpe_pkg::*;

  logic              fill_mode_q, fill_mode_d;
  logic [ColorW-1:0] pen_q, pen_d, back_q, back_d;
  logic [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CoordW-1:0] row_start_q, row_start_d, row_end_q, row_end_d;
  logic [CoordW-1:0] y_end_q, y_end_d;
  logic              active_q, active_d;

  logic              in_acc;
  logic [CoordW-1:0] end_x, end_y, next_x, next_y;
  logic [PixPerByte-1:0] wmask;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  assign colors_o.pen  = pen_q;
  assign colors_o.back = back_q;

  // Configuration register writes.
  always_comb begin
    fill_mode_d = fill_mode_q;
    pen_d       = pen_q;
    back_d      = back_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FILL_MODE:  fill_mode_d = cfg_data_i[0];
        CFG_PEN_COLOR:  pen_d       = cfg_data_i;
        CFG_BACK_COLOR: back_d      = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Picture extents and cursor advance.
  assign end_x  = origin_x_i + pic_width_i;
  assign end_y  = origin_y_i + pic_height_i;
  assign next_x = cur_x_q + CoordW'(PixPerByte);
  assign next_y = cur_y_q + CoordW'(1);
  assign wmask  = fill_mode_q ? {PixPerByte{1'b1}} : bitmap_byte_i;

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    row_start_d = row_start_q;
    row_end_d   = row_end_q;
    y_end_d     = y_end_q;
    active_d    = active_q;
    push_o      = 1'b0;
    if (in_acc) begin
      if (kind_i == KIND_START) begin
        row_start_d = origin_x_i;
        cur_x_d     = origin_x_i;
        cur_y_d     = origin_y_i;
        row_end_d   = end_x;
        y_end_d     = end_y;
        active_d    = (origin_x_i < end_x) && (origin_y_i < end_y);
      end else if (active_q) begin
        // A transparent zero byte moves the cursor but paints nothing.
        push_o = |wmask;
        if (next_x >= row_end_q) begin
          cur_x_d = row_start_q;
          cur_y_d = next_y;
          if (next_y >= y_end_q) begin
            active_d = 1'b0;
          end
        end else begin
          cur_x_d = next_x;
        end
      end
    end
  end

  assign push_job_o.x     = cur_x_q;
  assign push_job_o.y     = cur_y_q;
  assign push_job_o.bits  = bitmap_byte_i;
  assign push_job_o.wmask = wmask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_mode_q <= 1'b0;
      pen_q       <= PenColorRst;
      back_q      <= BackColorRst;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      row_start_q <= '0;
      row_end_q   <= '0;
      y_end_q     <= '0;
      active_q    <= 1'b0;
    end else begin
      fill_mode_q <= fill_mode_d;
      pen_q       <= pen_d;
      back_q      <= back_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      row_start_q <= row_start_d;
      row_end_q   <= row_end_d;
      y_end_q     <= y_end_d;
      active_q    <= active_d;
    end
  end

  // A job is only queued for an accepted byte of an active picture.
  a_push_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (in_acc && kind_i == KIND_BYTE && active_q))
    else $error("job queued without an active byte transfer");

  // An empty picture never becomes active on its start item.
  a_empty_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_START && pic_width_i == '0) |=> !active_q)
    else $error("zero-width picture became active");

endmodule

// ----- rtl/mbpe_queue.sv -----
// Small job queue between the front and the back end.
// Register-based FIFO; depends on mbpe_pkg for the job type.
module mbpe_queue #(
  parameter int unsigned Depth = mbpe_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mbpe_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output mbpe_pkg::job_t pop_job_o,
  output logic           empty_o
);
  import mbpe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_job_o = slots_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage is payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");

endmodule

// ----- rtl/mbpe_back.sv -----
// Back end: walks the pending pixels of one job, one pixel write per unstalled cycle.
// Holds the current job in registers; depends on mbpe_pkg.
module mbpe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Queue pop side
  input  logic                        q_empty_i,
  input  mbpe_pkg::job_t              q_job_i,
  output logic                        pop_o,
  input  mbpe_pkg::colors_t           colors_i,
  // Pixel output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mbpe_pkg::CoordW-1:0] pixel_x_o,
  output logic [mbpe_pkg::CoordW-1:0] pixel_y_o,
  output logic [mbpe_pkg::ColorW-1:0] pixel_color_o,
  output logic                        last_of_byte_o
);
  import mbpe_pkg::*;

  localparam int unsigned IdxW = $clog2(PixPerByte);

  logic                  busy_q, busy_d;
  job_t                  job_q, job_d;
  logic [PixPerByte-1:0] sel;
  logic [IdxW-1:0]       idx;
  logic [PixPerByte-1:0] rest;
  logic                  out_acc;

  // Leftmost pending pixel; bit 7 is pixel 0.
  always_comb begin
    sel = '0;
    idx = '0;
    for (int i = 0; i < PixPerByte; i++) begin
      if (job_q.wmask[PixPerByte-1-i] && sel == '0) begin
        sel[PixPerByte-1-i] = 1'b1;
        idx                 = IdxW'(i);
      end
    end
  end

  assign rest    = job_q.wmask & ~sel;
  assign out_acc = out_valid_o & ~out_stall_i;

  assign out_valid_o    = busy_q;
  assign pixel_x_o      = job_q.x + CoordW'(idx);
  assign pixel_y_o      = job_q.y;
  assign pixel_color_o  = |(job_q.bits & sel) ? colors_i.pen : colors_i.back;
  assign last_of_byte_o = (rest == '0);

  // Retire a pixel, and take the next job when idle or as the last pixel leaves.
  always_comb begin
    busy_d = busy_q;
    job_d  = job_q;
    pop_o  = 1'b0;
    if (out_acc) begin
      job_d.wmask = rest;
      if (rest == '0) begin
        busy_d = 1'b0;
      end
    end
    if ((!busy_q || (out_acc && rest == '0)) && !q_empty_i) begin
      pop_o  = 1'b1;
      busy_d = 1'b1;
      job_d  = q_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // The job payload needs no reset; busy_q qualifies it.
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  // A live job always has at least one pixel left to write.
  a_busy_has_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (job_q.wmask != '0))
    else $error("current job has no pending pixel");

  // The selected pixel is a single bit of the pending set.
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ($onehot(sel) && ((sel & job_q.wmask) == sel)))
    else $error("pixel select is not a single pending bit");

endmodule

// ----- rtl/mono_bitmap_pixel_expander_top.sv -----
// When the back is idle, a byte transfer goes through the job queue into the back end's job
// register before its first pixel write. Throughput: one pixel write per cycle while the output
// is not stalled, bounded by the single pixel output port of the back end. A byte paints its
// set bits, or all eight in backfill mode; a start item or a dropped byte gives no pixel writes.
// Reset (rst_ni, asynchronous, active low) clears the cursor, ends any picture, empties the
// queue and sets fill mode transparent, pen color 0x0000 and background 0xFFFF.
module mono_bitmap_pixel_expander_top #(
  parameter int unsigned QDepth = mbpe_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mbpe_pkg::ColorW-1:0] cfg_data_i,
  // Input item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [mbpe_pkg::CoordW-1:0] origin_x_i,
  input  logic [mbpe_pkg::CoordW-1:0] origin_y_i,
  input  logic [mbpe_pkg::CoordW-1:0] pic_width_i,
  input  logic [mbpe_pkg::CoordW-1:0] pic_height_i,
  input  logic [7:0]                  bitmap_byte_i,
  // Pixel output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mbpe_pkg::CoordW-1:0] pixel_x_o,
  output logic [mbpe_pkg::CoordW-1:0] pixel_y_o,
  output logic [mbpe_pkg::ColorW-1:0] pixel_color_o,
  output logic                        last_of_byte_o
);
  import mbpe_pkg::*;

  logic    push, q_full, pop, q_empty;
  job_t    push_job, pop_job;
  colors_t colors;

  // Front end: config, start items, cursor.
  mbpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .pic_width_i   (pic_width_i),
    .pic_height_i  (pic_height_i),
    .bitmap_byte_i (bitmap_byte_i),
    .push_o        (push),
    .push_job_o    (push_job),
    .q_full_i      (q_full),
    .colors_o      (colors)
  );

  // Job queue between the two halves.
  mbpe_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  // Back end: pixel writes.
  mbpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_job_i        (pop_job),
    .pop_o          (pop),
    .colors_i       (colors),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_of_byte_o (last_of_byte_o)
  );

endmodule

// ----- dv/mbpe_pixel_checker.sv -----
`timescale 1ns / 1ps
// Pixel write checker for the monochrome bitmap pixel expander testbench.
// Watches the configuration, input and pixel channels, predicts every pixel write
// and compares it field by field. Depends on mbpe_pkg.
module mbpe_pixel_checker
  import mbpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [ColorW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              kind_i,
  input  logic [CoordW-1:0] origin_x_i,
  input  logic [CoordW-1:0] origin_y_i,
  input  logic [CoordW-1:0] pic_width_i,
  input  logic [CoordW-1:0] pic_height_i,
  input  logic [7:0]        bitmap_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [CoordW-1:0] pixel_x_i,
  input  logic [CoordW-1:0] pixel_y_i,
  input  logic [ColorW-1:0] pixel_color_i,
  input  logic              last_of_byte_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_t;

  // Pixel writes predicted but not yet seen on the output.
  pixel_t expected_pixels[$];

  // Shadow copy of the configuration registers.
  logic              backfill;
  logic [ColorW-1:0] pen;
  logic [ColorW-1:0] back;

  // Shadow copy of the drawing cursor and picture bounds.
  logic [CoordW-1:0] cur_x;
  logic [CoordW-1:0] cur_y;
  logic [CoordW-1:0] row_x0;
  logic [CoordW-1:0] row_x_end;
  logic [CoordW-1:0] y_end;
  logic              drawing;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Compare one pixel transfer with the oldest expected write.
  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel write: x %h y %h color %h last %b",
             pixel_x_i, pixel_y_i, pixel_color_i, last_of_byte_i);
      fail_count_o++;
    end else begin
      want = expected_pixels.pop_front();
      if (pixel_x_i !== want.x) begin
        $error("pixel_x: expected %h, actual %h", want.x, pixel_x_i);
        fail_count_o++;
      end
      if (pixel_y_i !== want.y) begin
        $error("pixel_y: expected %h, actual %h", want.y, pixel_y_i);
        fail_count_o++;
      end
      if (pixel_color_i !== want.color) begin
        $error("pixel_color: expected %h, actual %h", want.color, pixel_color_i);
        fail_count_o++;
      end
      if (last_of_byte_i !== want.last) begin
        $error("last_of_byte: expected %b, actual %b", want.last, last_of_byte_i);
        fail_count_o++;
      end
    end
  endtask

  // Apply one input transfer to the shadow state and queue the writes it causes.
  task automatic expand_item();
    pixel_t      pix;
    logic [7:0]  paint;
    int          low_bit;
    int          i;
    if (kind_i == KIND_START) begin
      row_x0    = origin_x_i;
      cur_x     = origin_x_i;
      cur_y     = origin_y_i;
      row_x_end = origin_x_i + pic_width_i;
      y_end     = origin_y_i + pic_height_i;
      drawing   = (origin_x_i < row_x_end) && (origin_y_i < y_end);
    end else if (drawing) begin
      // Transparent mode paints set bits only; the lowest painted bit closes the byte.
      paint   = backfill ? 8'hFF : bitmap_byte_i;
      low_bit = 8;
      for (i = 7; i >= 0; i--) begin
        if (paint[i]) low_bit = i;
      end
      for (i = 7; i >= 0; i--) begin
        if (paint[i]) begin
          pix.x     = cur_x + CoordW'(7 - i);
          pix.y     = cur_y;
          pix.color = bitmap_byte_i[i] ? pen : back;
          pix.last  = (i == low_bit);
          expected_pixels.push_back(pix);
        end
      end
      // Step to the next byte; a row ends once the cursor reaches the row end.
      cur_x = cur_x + CoordW'(8);
      if (cur_x >= row_x_end) begin
        cur_x = row_x0;
        cur_y = cur_y + CoordW'(1);
        if (cur_y >= y_end) drawing = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backfill  = 1'b0;
      pen       = PenColorRst;
      back      = BackColorRst;
      cur_x     = '0;
      cur_y     = '0;
      row_x0    = '0;
      row_x_end = '0;
      y_end     = '0;
      drawing   = 1'b0;
      expected_pixels.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FILL_MODE:  backfill = cfg_data_i[0];
          CFG_PEN_COLOR:  pen = cfg_data_i;
          CFG_BACK_COLOR: back = cfg_data_i;
          default: ;
        endcase
      end
      // Outputs are checked before the new input is expanded, so a write never
      // matches an expectation created at the same edge.
      if (out_valid_i && !out_stall_i) check_pixel();
      if (in_valid_i && !in_stall_i) expand_item();
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the monochrome bitmap pixel expander.
// Drives configuration writes, pictures and bitmap bytes with random gaps and output stalls;
// relies on mbpe_pkg, the expander RTL and mbpe_pixel_checker for prediction.
module tb;
  import mbpe_pkg::*;

  localparam int CycleLimit    = 500000;
  localparam int RandomItems   = 300;
  localparam int HoldOffCycles = 150;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [ColorW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              kind_i;
  logic [CoordW-1:0] origin_x_i;
  logic [CoordW-1:0] origin_y_i;
  logic [CoordW-1:0] pic_width_i;
  logic [CoordW-1:0] pic_height_i;
  logic [7:0]        bitmap_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CoordW-1:0] pixel_x_o;
  logic [CoordW-1:0] pixel_y_o;
  logic [ColorW-1:0] pixel_color_o;
  logic              last_of_byte_o;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   useful_items = 0;
  int   calm_left = 0;
  logic gaps_off = 1'b0;
  logic hold_off_req = 1'b0;

  always #6 clk_i = ~clk_i;

  mono_bitmap_pixel_expander_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .pic_width_i    (pic_width_i),
    .pic_height_i   (pic_height_i),
    .bitmap_byte_i  (bitmap_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_of_byte_o (last_of_byte_o)
  );

  mbpe_pixel_checker pixel_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .pic_width_i    (pic_width_i),
    .pic_height_i   (pic_height_i),
    .bitmap_byte_i  (bitmap_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_i      (pixel_x_o),
    .pixel_y_i      (pixel_y_o),
    .pixel_color_i  (pixel_color_o),
    .last_of_byte_i (last_of_byte_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sender gap: mostly none or short, sometimes long, with calm stretches of none.
  function automatic int next_gap();
    int r;
    if (gaps_off) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_left = $urandom_range(10, 40);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Bitmap contents that favor the all-clear and all-set patterns.
  function automatic logic [7:0] pick_bits();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [ColorW-1:0] pick_color();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ColorW'($urandom);
  endfunction

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(input item_kind_e kind, input logic [CoordW-1:0] ox, oy, w, h,
                           input logic [7:0] bits);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    origin_x_i    <= ox;
    origin_y_i    <= oy;
    pic_width_i   <= w;
    pic_height_i  <= h;
    bitmap_byte_i <= bits;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_start(input logic [CoordW-1:0] ox, oy, w, h);
    send_item(KIND_START, ox, oy, w, h, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] bits);
    send_item(KIND_BYTE, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
              CoordW'($urandom), bits);
  endtask

  // Stop offering, wait for every expected write, then let the block settle.
  task automatic drain_and_pause();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ColorW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_colors(input logic fill, input logic [ColorW-1:0] pen, back);
    write_reg(CFG_FILL_MODE, ColorW'(fill));
    write_reg(CFG_PEN_COLOR, pen);
    write_reg(CFG_BACK_COLOR, back);
    cfg_valid_i <= 1'b0;
    repeat (2) @(negedge clk_i);
  endtask

  // A well-formed picture, sometimes cut short or followed by surplus bytes.
  task automatic send_picture();
    logic [CoordW-1:0] ox;
    logic [CoordW-1:0] oy;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    int                n_bytes;
    int                full;
    int                k;
    ox = ($urandom_range(0, 6) == 0) ? CoordW'(16'hFFFF - $urandom_range(0, 60))
                                     : CoordW'($urandom);
    oy = ($urandom_range(0, 6) == 0) ? CoordW'(16'hFFFF - $urandom_range(0, 8))
                                     : CoordW'($urandom);
    w  = CoordW'($urandom_range(1, 40));
    h  = CoordW'($urandom_range(1, 5));
    send_start(ox, oy, w, h);
    useful_items++;
    full    = ((int'(w) + 7) / 8) * int'(h);
    n_bytes = full;
    case ($urandom_range(0, 9))
      0: n_bytes = $urandom_range(0, full);
      1: n_bytes = full + $urandom_range(1, 3);
      default: ;
    endcase
    for (k = 0; k < n_bytes; k++) begin
      send_byte(pick_bits());
      if (k < full) useful_items++;
    end
  endtask

  // Stray bytes, or a start with unrestricted fields and a few bytes after it.
  task automatic send_noise();
    int n;
    int k;
    if ($urandom_range(0, 1) == 0) begin
      send_start(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
      useful_items++;
    end
    n = $urandom_range(0, 4);
    for (k = 0; k < n; k++) send_byte(8'($urandom));
  endtask

  // Output stall pattern: random short stalls, occasional long ones, calm stretches,
  // and one requested hold-off counted here.
  initial begin : pixel_receiver
    int hold_left;
    int burst_left;
    int r;
    logic burst_calm;
    hold_left   = 0;
    burst_left  = 0;
    burst_calm  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles - 1;
        out_stall_i  <= 1'b1;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          burst_calm = ($urandom_range(0, 3) == 0);
        end
        burst_left--;
        r = $urandom_range(0, 99);
        if (burst_calm) begin
          out_stall_i <= 1'b0;
        end else if (r < 3) begin
          hold_left   = $urandom_range(10, 40);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= (r < 30);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int k;
    int phase_target;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_FILL_MODE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_START;
    origin_x_i    = '0;
    origin_y_i    = '0;
    pic_width_i   = '0;
    pic_height_i  = '0;
    bitmap_byte_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset configuration: transparent, pen all zero, background all ones.
    // A byte before any picture is dropped.
    send_byte(8'hA5);
    // Two rows of two bytes, including a zero byte, then a byte past the end.
    send_start(16'h0000, 16'h0000, 16'd16, 16'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h81);
    send_byte(8'h01);
    send_byte(8'hFF);
    // Zero width gives an empty picture.
    send_start(16'd10, 16'd10, 16'd0, 16'd5);
    send_byte(8'hFF);
    // A right edge that wraps past the top of the range gives an empty picture too.
    send_start(16'hFFF0, 16'd3, 16'h0020, 16'd1);
    send_byte(8'hFF);
    drain_and_pause();

    // Backfill with inverted extreme colors.
    load_colors(1'b1, 16'hFFFF, 16'h0000);
    // Pixel coordinates wrap inside a byte, then the cursor wraps and the row goes on.
    send_start(16'hFFFC, 16'hFFFE, 16'd3, 16'd1);
    send_byte(8'h5A);
    send_byte(8'hC3);
    // Largest picture: all background, then all pen.
    send_start(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain_and_pause();

    // Long output hold-off while bytes keep coming back to back.
    hold_off_req = 1'b1;
    gaps_off     = 1'b1;
    send_start(16'd100, 16'd200, 16'd64, 16'd4);
    for (k = 0; k < 32; k++) send_byte(8'($urandom));
    gaps_off = 1'b0;

    // Random phases, each under a fresh configuration.
    while (useful_items < RandomItems) begin
      drain_and_pause();
      load_colors(1'($urandom), pick_color(), pick_color());
      phase_target = useful_items + 60;
      while (useful_items < phase_target) begin
        if ($urandom_range(0, 99) < 85) send_picture();
        else send_noise();
      end
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mbpe_pkg.sv
rtl/mbpe_front.sv
rtl/mbpe_queue.sv
rtl/mbpe_back.sv
rtl/mono_bitmap_pixel_expander_top.sv
dv/mbpe_pixel_checker.sv
dv/tb.sv
